// ===== rtl/rlerd_pkg.sv =====
package rlerd_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned RUN_W   = 7;
  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned PADDR_W = 3;

  localparam logic [CNT_W-1:0]   PIX_MAX       = 17'h1FFFF;
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST = 16'hFFFF;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // register indexes on the config port
  localparam logic REG_ROW_WIDTH = 1'b0;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_RUN     = 2'd2
  } phase_t;

  // one decoded command handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [RUN_W-1:0] run;
    logic             row_end;
  } cmd_t;

endpackage

// ===== rtl/rlerd_if.sv =====
interface rlerd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rlerd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic [6:0] run_length;
  logic       row_end;
  logic       overrun;

  modport source (output valid, output pixel_value, output run_length,
                  output row_end, output overrun, input ready);
  modport sink   (input valid, input pixel_value, input run_length,
                  input row_end, input overrun, output ready);
endinterface

// ===== rtl/rlerd_front.sv =====
module rlerd_front
  import rlerd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_byte,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  phase_t           phase_r, phase_nxt;
  logic [RUN_W-1:0] rem_r, rem_nxt;
  logic             take;
  logic [RUN_W-1:0] cnt;
  logic [RUN_W-1:0] rem_dec;

  assign in_ready = !q_full;
  assign take     = in_valid && !q_full;
  assign cnt      = in_byte[RUN_W-1:0];
  assign rem_dec  = rem_r - RUN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    q_push    = 1'b0;
    q_cmd     = '0;
    if (take) begin
      case (phase_r)
        PH_LITERAL: begin
          q_push        = 1'b1;
          q_cmd.pixel   = in_byte;
          q_cmd.run     = RUN_W'(1);
          rem_nxt       = rem_dec;
          if (rem_dec == '0) phase_nxt = PH_HEADER;
        end
        PH_RUN: begin
          q_push      = 1'b1;
          q_cmd.pixel = in_byte;
          q_cmd.run   = rem_r;
          rem_nxt     = '0;
          phase_nxt   = PH_HEADER;
        end
        default: begin
          if (cnt == '0) begin
            // zero count closes the row
            q_push        = 1'b1;
            q_cmd.row_end = 1'b1;
            rem_nxt       = '0;
            phase_nxt     = PH_HEADER;
          end else begin
            rem_nxt   = cnt;
            phase_nxt = in_byte[PIX_W-1] ? PH_LITERAL : PH_RUN;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/rlerd_queue.sv =====
module rlerd_queue
  import rlerd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t pop_cmd
);

  cmd_t           entry_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  assign full     = (count_r == (QAW+1)'(QDEPTH));
  assign nonempty = (count_r != '0);
  assign pop_cmd  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !nonempty)) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/rlerd_back.sv =====
module rlerd_back
  import rlerd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [WIDTH_W-1:0] row_width,
  input  logic               q_nonempty,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_pixel,
  output logic [RUN_W-1:0]   out_run,
  output logic               out_row_end,
  output logic               out_overrun
);

  logic [CNT_W-1:0] pix_cnt_r, pix_cnt_nxt;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic [RUN_W-1:0] out_run_r;
  logic             out_row_end_r;
  logic             out_overrun_r;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] sat;
  logic             ovr;

  assign q_pop = q_nonempty && (!out_valid_r || out_ready);

  // row end carries a zero run, so the same sum serves its overrun test
  assign sum = {1'b0, pix_cnt_r} + (CNT_W+1)'(q_cmd.run);
  assign sat = sum[CNT_W] ? PIX_MAX : sum[CNT_W-1:0];
  assign ovr = sat > CNT_W'(row_width);
  assign pix_cnt_nxt = q_cmd.row_end ? '0 : sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        pix_cnt_r   <= pix_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_pixel_r   <= q_cmd.pixel;
      out_run_r     <= q_cmd.run;
      out_row_end_r <= q_cmd.row_end;
      out_overrun_r <= ovr;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel   = out_pixel_r;
  assign out_run     = out_run_r;
  assign out_row_end = out_row_end_r;
  assign out_overrun = out_overrun_r;

`ifndef SYNTHESIS
  a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_cmd.row_end |=> pix_cnt_r == '0)
    else $error("pixel count not cleared at row end");
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && !q_cmd.row_end |=> pix_cnt_r >= $past(pix_cnt_r))
    else $error("pixel count went backwards within a row");
  a_row_end_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_row_end_r |-> out_run_r == '0 && out_pixel_r == '0)
    else $error("row end item carries pixel data");
`endif

endmodule

// ===== rtl/rle_row_decoder_unit.sv =====
// Run-length decoder for one compressed image row, one byte per input item.
// Takes one byte every clock cycle while the queue is not full, and gives
// at most one result per byte: a header byte only updates the decode state,
// a literal or run value byte gives a pixel with its repeat count, and a
// zero-count header gives a row end. A four entry queue between the byte
// parser and the pixel counter absorbs output stalls, and in_ch.ready drops
// only when that queue is full. Overrun compares the saturating pixel count
// of the row (including this result) with row_width, written at address 0
// to 3; the user must do so only while the block is idle (not enforced).
module rle_row_decoder_unit
  import rlerd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  rlerd_in_if.sink             in_ch,
  rlerd_out_if.source          out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [WIDTH_W-1:0] row_width_r;
  logic               cfg_wr;
  logic               cfg_hit;
  logic               q_full, q_push, q_pop, q_nonempty;
  cmd_t               push_cmd, pop_cmd;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PADDR_W-1] == REG_ROW_WIDTH);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? {16'h0, row_width_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
    end else if (cfg_wr) begin
      row_width_r <= pwdata[WIDTH_W-1:0];
    end
  end

  rlerd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.data_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  rlerd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_cmd  (pop_cmd)
  );

  rlerd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .row_width   (row_width_r),
    .q_nonempty  (q_nonempty),
    .q_cmd       (pop_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_pixel   (out_ch.pixel_value),
    .out_run     (out_ch.run_length),
    .out_row_end (out_ch.row_end),
    .out_overrun (out_ch.overrun)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  import rlerd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic [RUN_W-1:0] run;
    logic             row_end;
    logic             overrun;
  } pix_result_t;

  class rle_scoreboard;
    logic [WIDTH_W-1:0] row_width;
    phase_t             phase;
    logic [RUN_W-1:0]   remaining;
    logic [CNT_W-1:0]   pix_count;
    pix_result_t        pending_pixels[$];
    int                 errors;
    int                 shown;

    function void clear();
      row_width = ROW_WIDTH_RST;
      phase = PH_HEADER;
      remaining = '0;
      pix_count = '0;
      pending_pixels.delete();
      errors = 0;
      shown = 0;
    endfunction

    function void set_width(logic [WIDTH_W-1:0] w);
      row_width = w;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void fail(string msg);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%s", msg);
      end
    endfunction

    // pixel count of the row saturates instead of wrapping
    function void add_pixels(int unsigned n);
      int unsigned sum;
      sum = pix_count + n;
      pix_count = (sum > PIX_MAX) ? PIX_MAX : sum[CNT_W-1:0];
    endfunction

    function void push(logic [PIX_W-1:0] pix, logic [RUN_W-1:0] run, logic row_end);
      pix_result_t r;
      r.pixel = pix;
      r.run = run;
      r.row_end = row_end;
      r.overrun = ({15'd0, pix_count} > {16'd0, row_width});
      pending_pixels.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      case (phase)
        PH_LITERAL: begin
          add_pixels(32'd1);
          push(b, 7'd1, 1'b0);
          remaining = remaining - 7'd1;
          if (remaining == '0) phase = PH_HEADER;
        end
        PH_RUN: begin
          add_pixels(32'(remaining));
          push(b, remaining, 1'b0);
          remaining = '0;
          phase = PH_HEADER;
        end
        default: begin
          if (b[6:0] == '0) begin
            // row end reports the overrun of the row it closes
            push('0, '0, 1'b1);
            pix_count = '0;
            remaining = '0;
            phase = PH_HEADER;
          end else begin
            remaining = b[6:0];
            phase = b[7] ? PH_LITERAL : PH_RUN;
          end
        end
      endcase
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic [RUN_W-1:0] run,
                               logic row_end, logic overrun);
      pix_result_t e;
      if (pending_pixels.size() == 0) begin
        fail($sformatf("unexpected item: pixel %h run %0d end %b ovr %b",
                       pix, run, row_end, overrun));
        return;
      end
      e = pending_pixels.pop_front();
      if (pix !== e.pixel || run !== e.run || row_end !== e.row_end ||
          overrun !== e.overrun)
        fail($sformatf("bad item: exp pixel %h run %0d end %b ovr %b, got pixel %h run %0d end %b ovr %b",
                       e.pixel, e.run, e.row_end, e.overrun, pix, run, row_end, overrun));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rlerd_in_if  in_ch();
  rlerd_out_if out_ch();

  rle_row_decoder_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rle_scoreboard sb;
  logic [7:0] stream[$];
  int idle_in = 27;
  int idle_out = 27;
  logic hold_off = 1'b0;
  int unsigned cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rle_row_decoder_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.pixel_value, out_ch.run_length, out_ch.row_end,
                        out_ch.overrun);
    end
  end

  // receiver side
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(99, 0) >= idle_out);
    end
  end

  function automatic void add_noise();
    repeat ($urandom_range(6, 1)) stream.push_back(8'($urandom_range(255, 0)));
  endfunction

  // well-formed row with random packets; a few lose their end marker
  function automatic void add_row();
    int cnt;
    bit lit;
    int r;
    repeat ($urandom_range(5, 0)) begin
      lit = 1'($urandom_range(1, 0));
      cnt = ($urandom_range(9, 0) == 0) ? $urandom_range(127, 1) : $urandom_range(8, 1);
      stream.push_back({lit, cnt[6:0]});
      if (lit) repeat (cnt) stream.push_back(8'($urandom_range(255, 0)));
      else stream.push_back(8'($urandom_range(255, 0)));
    end
    r = $urandom_range(99, 0);
    if (r >= 6) stream.push_back(r[0] ? 8'h80 : 8'h00);
  endfunction

  function automatic void fill_random(int n);
    stream.delete();
    while (stream.size() < n) begin
      if ($urandom_range(9, 0) == 0) add_noise();
      else add_row();
    end
  endfunction

  task automatic send_stream();
    @(negedge clk);
    foreach (stream[i]) begin
      while ($urandom_range(99, 0) < idle_in) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.data_byte <= stream[i];
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;
  endtask

  // wait for every expected item, then let the pipeline settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(logic [WIDTH_W-1:0] w);
    logic [31:0] word;
    word = $urandom;
    word[WIDTH_W-1:0] = w;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_ROW_WIDTH, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_width(w);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes of the header and value bytes, both end markers
    stream = '{8'h00, 8'h80, 8'h01, 8'hFF, 8'h7F, 8'h00, 8'h82, 8'h00, 8'hFF,
               8'h81, 8'h5A, 8'h00, 8'h03, 8'hAA, 8'h02, 8'h55, 8'h80};
    send_stream();
    drain();

    write_width(16'd1);
    fill_random(80);
    send_stream();
    drain();

    // zero width: every pixel overruns
    write_width(16'd0);
    fill_random(80);
    send_stream();
    drain();

    for (int k = 0; k < 8; k++) begin
      write_width((k == 7) ? 16'($urandom_range(65535, 61)) : 16'($urandom_range(60, 1)));
      if (k == 2) begin
        idle_in = 0;
        idle_out = 0;
      end
      fill_random(50);
      if (k == 4) begin
        fork
          send_stream();
          begin
            repeat (16) @(posedge clk);
            hold_off = 1'b1;
            repeat (64) @(posedge clk);
            hold_off = 1'b0;
          end
        join
      end else begin
        send_stream();
      end
      drain();
      idle_in = 27;
      idle_out = 27;
    end

    // one long row that runs past the full width
    write_width(16'hFFFF);
    fill_random(20);
    repeat (520) begin
      stream.push_back(8'h7F);
      stream.push_back(8'($urandom_range(255, 0)));
    end
    stream.push_back(8'h00);
    add_row();
    stream.push_back(8'h00);
    send_stream();
    drain();
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rle_row_decoder_unit: match");
    end else begin
      $display("rle_row_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule
